### hw/rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int MAX_WIDTH  = 20;
    localparam int VALUE_BITS = 32;

    localparam int RADIX_W    = 6;
    localparam int FWIDTH_W   = 5;
    localparam int CHAR_W     = 8;

    localparam int RADIX_MIN  = 2;
    localparam int RADIX_MAX  = 36;
    localparam int LETTER_GAP = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // divider: quotient bits resolved per cycle
    localparam int DIV_BPC   = 8;
    localparam int DIV_STEPS = (VALUE_BITS + DIV_BPC - 1) / DIV_BPC;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int DIG_W   = $clog2(VALUE_BITS + 1);
    localparam int IDX_W   = $clog2(VALUE_BITS);
    localparam int LEN_MAX = (VALUE_BITS + 1 > MAX_WIDTH) ? VALUE_BITS + 1 : MAX_WIDTH;
    localparam int LEN_W   = $clog2(LEN_MAX + 1);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic [RADIX_W-1:0]    radix;
        logic                  neg;
        logic [FWIDTH_W-1:0]   fwidth;
        logic                  zero_pad;
    } itoa_cmd_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = CHAR_ZERO + CHAR_W'(d);
        if (d >= RADIX_W'(10))
            c = c + CHAR_W'(LETTER_GAP);
        return c;
    endfunction

endpackage

### hw/rtl/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// Accepts input beats, drops out-of-range requests, takes the magnitude.
// ----------------------------------------------------------------------------
module itoa_front (
    input  logic [itoa_pkg::VALUE_BITS-1:0] value,
    input  logic [itoa_pkg::RADIX_W-1:0]    radix,
    input  logic                            signed_mode,
    input  logic [itoa_pkg::FWIDTH_W-1:0]   width,
    input  logic                            zero_pad,
    input  logic                            push,
    output logic                            full,
    input  logic                            q_full,
    output logic                            q_push,
    output itoa_pkg::itoa_cmd_t             q_cmd
);
    import itoa_pkg::*;

    logic ok;
    logic neg;

    assign ok  = (width <= FWIDTH_W'(MAX_WIDTH)) &&
                 (radix >= RADIX_W'(RADIX_MIN)) &&
                 (radix <= RADIX_W'(RADIX_MAX));
    assign neg = signed_mode & value[VALUE_BITS-1];

    assign full   = q_full;
    assign q_push = push & ~q_full & ok;

    always_comb
    begin
        q_cmd.mag      = neg ? (~value + VALUE_BITS'(1)) : value;
        q_cmd.radix    = radix;
        q_cmd.neg      = neg;
        q_cmd.fwidth   = width;
        q_cmd.zero_pad = zero_pad;
    end

endmodule

### hw/rtl/itoa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// itoa_cmd_fifo
// Short command queue between the front and the conversion engine.
// ----------------------------------------------------------------------------
module itoa_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  itoa_pkg::itoa_cmd_t wr_data,
    output logic                is_full,
    input  logic                rd_en,
    output logic                rd_valid,
    output itoa_pkg::itoa_cmd_t rd_data
);
    import itoa_pkg::*;

    itoa_cmd_t               mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]   wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0]   rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0]   cnt_reg;
    logic                    do_wr;
    logic                    do_rd;

    assign is_full  = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en & ~is_full;
    assign do_rd    = rd_en & rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### hw/rtl/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// Digit engine: repeated division by the radix, then character emission.
// ----------------------------------------------------------------------------
module itoa_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  itoa_pkg::itoa_cmd_t           cmd,
    output logic                          cmd_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [itoa_pkg::CHAR_W-1:0]   character,
    output logic                          last
);
    import itoa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   quo_reg, quo_next;
    logic [RADIX_W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [DIG_W-1:0]        ndig_reg, ndig_next;
    logic [LEN_W-1:0]        k_reg, k_next;
    logic [RADIX_W-1:0]      radix_reg, radix_next;
    logic                    neg_reg, neg_next;
    logic [FWIDTH_W-1:0]     fwidth_reg, fwidth_next;
    logic                    zpad_reg, zpad_next;
    logic                    ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]       char_reg, char_next;
    logic                    last_reg, last_next;

    logic [CHAR_W-1:0]       store_reg [VALUE_BITS];
    logic                    store_we;
    logic [CHAR_W-1:0]       store_wdata;

    logic [VALUE_BITS-1:0]   w;
    logic [RADIX_W-1:0]      r;
    logic [RADIX_W:0]        rt;
    logic [LEN_W-1:0]        body_len;
    logic [LEN_W-1:0]        total_len;
    logic [CHAR_W-1:0]       emit_char;
    logic                    slot_free;

    // one division pass: DIV_BPC restoring steps
    always_comb
    begin
        r  = rem_reg;
        w  = quo_reg;
        rt = '0;
        for (int i = 0; i < DIV_BPC; i++)
        begin
            if ((int'(step_reg) * DIV_BPC + i) < VALUE_BITS)
            begin
                rt = {r, w[VALUE_BITS-1]};
                w  = {w[VALUE_BITS-2:0], 1'b0};
                if (rt >= {1'b0, radix_reg})
                begin
                    rt   = rt - {1'b0, radix_reg};
                    w[0] = 1'b1;
                end
                r = rt[RADIX_W-1:0];
            end
        end
    end

    assign body_len  = LEN_W'(ndig_reg) + LEN_W'(1) + LEN_W'(neg_reg);
    assign total_len = (body_len > LEN_W'(fwidth_reg)) ? body_len : LEN_W'(fwidth_reg);
    assign slot_free = ~ovalid_reg | pop;

    // k counts characters from the right end of the field
    always_comb
    begin
        if (k_reg < LEN_W'(ndig_reg))
            emit_char = store_reg[k_reg[IDX_W-1:0]];
        else if (neg_reg && (k_reg == LEN_W'(ndig_reg)))
            emit_char = CHAR_MINUS;
        else
            emit_char = zpad_reg ? CHAR_ZERO : CHAR_SPACE;
    end

    always_comb
    begin
        state_next  = state_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        ndig_next   = ndig_reg;
        k_next      = k_reg;
        radix_next  = radix_reg;
        neg_next    = neg_reg;
        fwidth_next = fwidth_reg;
        zpad_next   = zpad_reg;
        ovalid_next = ovalid_reg & ~pop;
        char_next   = char_reg;
        last_next   = last_reg;
        cmd_pop     = 1'b0;
        store_we    = 1'b0;
        store_wdata = digit_char(r);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    quo_next    = cmd.mag;
                    rem_next    = '0;
                    step_next   = '0;
                    ndig_next   = '0;
                    radix_next  = cmd.radix;
                    neg_next    = cmd.neg;
                    fwidth_next = cmd.fwidth;
                    zpad_next   = cmd.zero_pad;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = w;
                rem_next = r;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    store_we  = 1'b1;
                    ndig_next = ndig_reg + 1'b1;
                    rem_next  = '0;
                    step_next = '0;
                    if (w == '0)
                    begin
                        k_next     = total_len - 1'b1;
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    char_next   = emit_char;
                    last_next   = (k_reg == '0);
                    if (k_reg == '0)
                        state_next = ST_IDLE;
                    else
                        k_next = k_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[ndig_reg[IDX_W-1:0]] <= store_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        ndig_reg   <= ndig_next;
        k_reg      <= k_next;
        radix_reg  <= radix_next;
        neg_reg    <= neg_next;
        fwidth_reg <= fwidth_next;
        zpad_reg   <= zpad_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign empty     = ~ovalid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

### hw/rtl/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats a 32-bit integer as right-aligned ASCII text in radix 2..36.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a request beat (value, radix, signed_mode,
// width, zero_pad) is taken when push is high and full is low. Requests with
// a radix outside 2..36 or a width above 20 are taken and produce nothing.
// Output side is a queue read port: while empty is low, character/last hold
// the oldest pending character; pop high consumes it. last marks the final
// character of a number. Characters leave most significant first, padding
// ahead of the minus sign.
// Flow: a request waits in a two-entry command queue, then the digit engine
// divides the 32-bit value by the radix once per digit, resolving 8 quotient
// bits per cycle, and then emits the characters of the number one by one; it
// takes the next request only after the last character has been emitted.
// The engine holds at the output register while pop stays low; the queue
// keeps taking up to two further requests meanwhile. Reset empties the queue
// and the output register.
module integer_to_ascii_formatter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [itoa_pkg::VALUE_BITS-1:0] value,
    input  logic [itoa_pkg::RADIX_W-1:0]    radix,
    input  logic                            signed_mode,
    input  logic [itoa_pkg::FWIDTH_W-1:0]   width,
    input  logic                            zero_pad,
    input  logic                            push,
    output logic                            full,
    output logic                            empty,
    input  logic                            pop,
    output logic [itoa_pkg::CHAR_W-1:0]     character,
    output logic                            last
);
    import itoa_pkg::*;

    itoa_cmd_t q_wr_cmd;
    itoa_cmd_t q_rd_cmd;
    logic      q_push;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;

    itoa_front u_front (
        .value       (value),
        .radix       (radix),
        .signed_mode (signed_mode),
        .width       (width),
        .zero_pad    (zero_pad),
        .push        (push),
        .full        (full),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_wr_cmd)
    );

    itoa_cmd_fifo u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wr_cmd),
        .is_full  (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_cmd)
    );

    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_rd_cmd),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last      (last)
    );

endmodule

### hw/rtl/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
module itoa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] character,
    input logic       last
);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(character) && $stable(last)))
    else $error("stalled output beat changed");

    assert property (@(posedge clk) !rst_n |-> (empty && !full))
    else $error("queues not empty in reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((character >= 8'h30 && character <= 8'h39) ||
                    (character >= 8'h41 && character <= 8'h5A) ||
                    character == 8'h2D || character == 8'h20))
    else $error("illegal output character");

    // sign and blank padding always precede a digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (character == 8'h2D || character == 8'h20)) |-> !last)
    else $error("number ends without a digit");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last      (last)
);
